// ===== rtl/bab_pkg.sv =====
// Shared types and constants for the block allocation bitmap unit.
// No dependencies; imported by every module of the unit except bab_ram.
`timescale 1ns / 1ps

package bab_pkg;

  // Geometry of the used map
  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = $clog2(MAP_WORDS);

  // Field widths
  localparam int REQ_W = 3;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;

  localparam logic [CNT_W-1:0] NB_RESET = CNT_W'(MAX_BLOCKS);

  typedef enum logic [REQ_W-1:0] {
    REQ_CHECK_READ = 3'd0,
    REQ_WRITE      = 3'd1,
    REQ_FREE       = 3'd2,
    REQ_FIND_FREE  = 3'd3,
    REQ_FORMAT     = 3'd4
  } bab_req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH
  } bab_state_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] block_index;
  } bab_req_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] found_index;
    logic             none_found;
    logic [CNT_W-1:0] free_count;
    logic [IDX_W-1:0] first_free;
    logic             first_free_valid;
  } bab_res_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic search;
    logic finish;
  } bab_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_search;
    logic search_end;
  } bab_stat_t;

endpackage

// ===== rtl/bab_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-during-write to the same address returns the old data. No dependencies.
`timescale 1ns / 1ps

module bab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bab_ctrl.sv =====
// Request sequencer: idle, evaluate one map word, then scan words for a search.
// Depends on bab_pkg.
`timescale 1ns / 1ps

module bab_ctrl
  import bab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  bab_stat_t stat_i,
  output bab_cmd_t  cmd_o,
  output logic      busy
);

  bab_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = stat_i.need_search ? ST_SEARCH : ST_IDLE;
      end
      ST_SEARCH: begin
        if (stat_i.search_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_EVAL: begin
        cmd_o.eval   = 1'b1;
        cmd_o.finish = !stat_i.need_search;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        cmd_o.finish = stat_i.search_end;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/bab_dp.sv =====
// Datapath: used-map RAM with per-word valid bits, count, first-free pointer,
// word scanner and result register. Depends on bab_pkg and bab_ram.
`timescale 1ns / 1ps

module bab_dp
  import bab_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bab_req_t         req_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  bab_cmd_t         cmd_i,
  output bab_stat_t        stat_o,
  output logic             done_o,
  output bab_res_t         res_o
);

  // Bookkeeping
  logic [CNT_W-1:0]     nb_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     lf_q, lf_d;
  logic                 lfv_q, lfv_d;
  logic [MAP_WORDS-1:0] wvalid_q, wvalid_d;

  // Item and scan state
  bab_req_t             req_q;
  logic [WADDR_W-1:0]   ptr_q, ptr_d;
  logic                 first_q, first_d;
  logic [BIT_W-1:0]     sbit_q, sbit_d;
  logic                 vrd_q;
  bab_res_t             res_q, res_d;
  logic                 done_q;

  // RAM
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  // Evaluation
  logic [WORD_W-1:0]    word, bit_oh;
  logic                 in_range, cur_bit;
  logic [CNT_W-1:0]     wr_start, sstart, nb_m1;
  logic [WADDR_W-1:0]   last_word;
  logic [BIT_W-1:0]     last_bit, lim_sh, enc;
  logic [WORD_W-1:0]    start_mask, lim_mask, free_vec;
  logic                 hit, at_last, lf_hit;
  logic [IDX_W-1:0]     found_idx;
  logic                 status_c, none_c;
  logic [IDX_W-1:0]     found_c;

  function automatic logic [CNT_W-1:0] clamp_nb(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > NB_RESET) r = NB_RESET;
    return r;
  endfunction

  bab_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A word never written since reset or format reads as all free
  assign word     = vrd_q ? ram_rdata : '0;
  assign in_range = CNT_W'(req_q.block_index) < nb_q;
  assign bit_oh   = WORD_W'(1) << req_q.block_index[BIT_W-1:0];
  assign cur_bit  = word[req_q.block_index[BIT_W-1:0]];
  assign wr_start = CNT_W'(req_q.block_index) + CNT_W'(1);
  assign sstart   = (req_q.req_type == REQ_WRITE) ? wr_start : CNT_W'(req_q.block_index);
  assign lf_hit   = lfv_q && (lf_q == req_q.block_index);

  assign nb_m1     = nb_q - CNT_W'(1);
  assign last_word = WADDR_W'(nb_m1 >> BIT_W);
  assign last_bit  = nb_m1[BIT_W-1:0];
  assign at_last   = (ptr_q == last_word);

  // Scan of one word: bits before the start and past the last block count as used
  assign lim_sh     = BIT_W'(WORD_W - 1) - last_bit;
  assign start_mask = first_q ? ({WORD_W{1'b1}} << sbit_q) : {WORD_W{1'b1}};
  assign lim_mask   = at_last ? ({WORD_W{1'b1}} >> lim_sh) : {WORD_W{1'b1}};
  assign free_vec   = ~word & start_mask & lim_mask;
  assign hit        = |free_vec;

  always_comb begin
    enc = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) enc = BIT_W'(i);
    end
  end

  assign found_idx = IDX_W'({ptr_q, enc});

  assign stat_o.need_search = in_range &&
      (((req_q.req_type == REQ_WRITE) && lf_hit && (wr_start < nb_q)) ||
       (req_q.req_type == REQ_FIND_FREE));
  assign stat_o.search_end  = hit || at_last;

  // Read port: item word on load, scan start on eval, next word while scanning
  always_comb begin
    if (cmd_i.load) ram_raddr = WADDR_W'(req_i.block_index >> BIT_W);
    else if (cmd_i.eval) ram_raddr = WADDR_W'(sstart >> BIT_W);
    else ram_raddr = ptr_q + WADDR_W'(1);
  end

  assign ram_waddr = WADDR_W'(req_q.block_index >> BIT_W);
  assign ram_wdata = (req_q.req_type == REQ_WRITE) ? (word | bit_oh) : (word & ~bit_oh);
  assign ram_we    = cmd_i.eval && in_range &&
                     ((req_q.req_type == REQ_WRITE) || (req_q.req_type == REQ_FREE));

  always_comb begin
    cnt_d    = cnt_q;
    lf_d     = lf_q;
    lfv_d    = lfv_q;
    wvalid_d = wvalid_q;
    ptr_d    = ptr_q;
    first_d  = first_q;
    sbit_d   = sbit_q;
    status_c = 1'b0;
    none_c   = 1'b0;
    found_c  = '0;

    if (ram_we) wvalid_d[ram_waddr] = 1'b1;

    if (cmd_i.eval) begin
      ptr_d   = WADDR_W'(sstart >> BIT_W);
      first_d = 1'b1;
      sbit_d  = sstart[BIT_W-1:0];
      case (req_q.req_type)
        REQ_CHECK_READ: begin
          status_c = !in_range || !cur_bit;
        end
        REQ_WRITE: begin
          if (!in_range) begin
            status_c = 1'b1;
          end else begin
            if (!cur_bit && (cnt_q != '0)) cnt_d = cnt_q - CNT_W'(1);
            // pointer on the last block: nothing left above it
            if (lf_hit && (wr_start >= nb_q)) begin
              lf_d  = '0;
              lfv_d = 1'b0;
            end
          end
        end
        REQ_FREE: begin
          if (!in_range) begin
            status_c = 1'b1;
          end else begin
            if (cur_bit && (cnt_q < nb_q)) cnt_d = cnt_q + CNT_W'(1);
            if (!lfv_q || (req_q.block_index < lf_q)) begin
              lf_d  = req_q.block_index;
              lfv_d = 1'b1;
            end
          end
        end
        REQ_FIND_FREE: begin
          if (!in_range) begin
            status_c = 1'b1;
            none_c   = 1'b1;
          end
        end
        REQ_FORMAT: begin
          wvalid_d = '0;
          cnt_d    = nb_q;
          lf_d     = '0;
          lfv_d    = 1'b1;
        end
        default: begin
          status_c = 1'b1;
        end
      endcase
    end

    if (cmd_i.search) begin
      ptr_d   = ptr_q + WADDR_W'(1);
      first_d = 1'b0;
      if (req_q.req_type == REQ_WRITE) begin
        lf_d  = hit ? found_idx : '0;
        lfv_d = hit;
      end else begin
        found_c = hit ? found_idx : '0;
        none_c  = !hit;
      end
    end
  end

  always_comb begin
    res_d.status           = status_c;
    res_d.found_index      = found_c;
    res_d.none_found       = none_c;
    res_d.free_count       = cnt_d;
    res_d.first_free       = lf_d;
    res_d.first_free_valid = lfv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q     <= NB_RESET;
      cnt_q    <= NB_RESET;
      lf_q     <= '0;
      lfv_q    <= 1'b1;
      wvalid_q <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) nb_q <= clamp_nb(cfg_wdata_i);
      cnt_q    <= cnt_d;
      lf_q     <= lf_d;
      lfv_q    <= lfv_d;
      wvalid_q <= wvalid_d;
      done_q   <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    ptr_q   <= ptr_d;
    first_q <= first_d;
    sbit_q  <= sbit_d;
    // valid bit sampled with the read so it matches the returned word
    vrd_q   <= wvalid_q[ram_raddr];
    if (cmd_i.finish) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/block_allocation_bitmap_unit.sv =====
// Top level of the free-block bitmap allocator: sequencer plus datapath.
// Depends on bab_pkg, bab_ctrl, bab_dp (and bab_ram below it).
//
//   channel   handshake            payload
//   request   start / busy         req_i  (bab_req_t)
//   result    done_o (strobe)      res_o  (bab_res_t)
//   config    cfg_we_i             cfg_wdata_i (store size in blocks)
//
// Check, free, format, bad type and out-of-range items pass through the evaluate state alone;
// an in-range find free and a write to the first-free block below the last block also scan
// map words in the search state (one 32-bit word per cycle, 1 to 128), busy in both states.
// The result strobe is high in the first cycle with busy low again; results cannot stall.
// After reset every word reads as free through per-word valid bits: no clearing pass.
`timescale 1ns / 1ps

module block_allocation_bitmap_unit
  import bab_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bab_req_t         req_i,
  output logic             done_o,
  output bab_res_t         res_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  bab_cmd_t  cmd;
  bab_stat_t stat;

  bab_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  bab_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/bab_checker.sv =====
// Port-level checks for the block allocation bitmap unit, bound to the top level.
// Depends on bab_pkg.
`timescale 1ns / 1ps

module bab_checker
  import bab_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input bab_res_t res_o
);

  // an accepted item raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // every item ends in exactly one strobe, right after busy drops
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result strobe");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result strobe without a finished item");

  a_lf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.first_free_valid) |-> (res_o.first_free == '0))
    else $error("invalid first-free pointer not zero");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.none_found) |-> (res_o.found_index == '0))
    else $error("found index not zero when nothing found");

endmodule

bind block_allocation_bitmap_unit bab_checker u_bab_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

// ===== tb/bab_alloc_checker.sv =====
// Checker for the block allocation bitmap unit: follows the request, result and config ports,
// keeps its own copy of the used map and pointer state, and compares every result item.
// Depends on bab_pkg.
`timescale 1ns / 1ps

module bab_alloc_checker
  import bab_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  bab_req_t         req_i,
  input  logic             done_o,
  input  bab_res_t         res_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output int               pending_o,
  output int               fail_cnt_o
);

  localparam int REPORT_MAX = 10;

  logic [MAX_BLOCKS-1:0] used_map;
  logic [CNT_W-1:0]      free_left;
  logic [IDX_W-1:0]      low_free;
  logic                  low_free_ok;
  int                    blocks_on;

  bab_res_t              alloc_res_q[$];

  // lowest free block in [from, blocks_on)
  function automatic logic scan_free(input int from, output int at);
    for (int i = from; i < blocks_on; i++) begin
      if (!used_map[i]) begin
        at = i;
        return 1'b1;
      end
    end
    at = 0;
    return 1'b0;
  endfunction

  task automatic apply_request(input bab_req_t rq, output bab_res_t r);
    int   idx;
    int   at;
    logic in_rng;
    idx    = int'(rq.block_index);
    in_rng = idx < blocks_on;
    r      = '0;
    case (rq.req_type)
      REQ_CHECK_READ: begin
        if (!in_rng || !used_map[idx]) r.status = 1'b1;
      end
      REQ_WRITE: begin
        if (!in_rng) begin
          r.status = 1'b1;
        end else begin
          if (low_free_ok && low_free == IDX_W'(idx)) begin
            if (scan_free(idx + 1, at)) begin
              low_free = IDX_W'(at);
            end else begin
              low_free    = '0;
              low_free_ok = 1'b0;
            end
          end
          if (!used_map[idx] && free_left != '0) free_left = free_left - CNT_W'(1);
          used_map[idx] = 1'b1;
        end
      end
      REQ_FREE: begin
        if (!in_rng) begin
          r.status = 1'b1;
        end else begin
          // count saturates at the configured store size
          if (used_map[idx] && free_left < CNT_W'(blocks_on)) free_left = free_left + CNT_W'(1);
          used_map[idx] = 1'b0;
          if (!low_free_ok || IDX_W'(idx) < low_free) begin
            low_free    = IDX_W'(idx);
            low_free_ok = 1'b1;
          end
        end
      end
      REQ_FIND_FREE: begin
        if (!in_rng) begin
          r.status     = 1'b1;
          r.none_found = 1'b1;
        end else if (scan_free(idx, at)) begin
          r.found_index = IDX_W'(at);
        end else begin
          r.none_found = 1'b1;
        end
      end
      REQ_FORMAT: begin
        used_map    = '0;
        free_left   = CNT_W'(blocks_on);
        low_free    = '0;
        low_free_ok = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    r.free_count       = free_left;
    r.first_free       = low_free;
    r.first_free_valid = low_free_ok;
  endtask

  task automatic log_miss(input string what, input bab_res_t want, input bab_res_t got);
    if (fail_cnt_o < REPORT_MAX) begin
      $display("%0t %s: exp st=%0d fi=%0d nf=%0d cnt=%0d ff=%0d ffv=%0d", $realtime, what,
               want.status, want.found_index, want.none_found, want.free_count,
               want.first_free, want.first_free_valid);
      $display("%0t %s: got st=%0d fi=%0d nf=%0d cnt=%0d ff=%0d ffv=%0d", $realtime, what,
               got.status, got.found_index, got.none_found, got.free_count,
               got.first_free, got.first_free_valid);
    end
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    bab_res_t want;
    if (!rst_ni) begin
      used_map    = '0;
      blocks_on   = MAX_BLOCKS;
      free_left   = NB_RESET;
      low_free    = '0;
      low_free_ok = 1'b1;
      alloc_res_q.delete();
      fail_cnt_o  = 0;
    end else begin
      if (done_o === 1'b1) begin
        if (alloc_res_q.size() == 0) begin
          log_miss("unexpected result", '0, res_o);
        end else begin
          want = alloc_res_q.pop_front();
          if (res_o.status !== want.status || res_o.found_index !== want.found_index ||
              res_o.none_found !== want.none_found || res_o.free_count !== want.free_count ||
              res_o.first_free !== want.first_free ||
              res_o.first_free_valid !== want.first_free_valid)
            log_miss("result mismatch", want, res_o);
        end
      end
      // register write clamps to 1..MAX_BLOCKS, state left alone
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0)                   blocks_on = 1;
        else if (cfg_wdata_i > CNT_W'(MAX_BLOCKS)) blocks_on = MAX_BLOCKS;
        else                                     blocks_on = int'(cfg_wdata_i);
      end
      if (start && !busy) begin
        apply_request(req_i, want);
        alloc_res_q.push_back(want);
      end
    end
    pending_o = alloc_res_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for block_allocation_bitmap_unit: clock, reset, request and config stimulus.
// Depends on bab_pkg, the unit's RTL and bab_alloc_checker, which gives the failure count.
`timescale 1ns / 1ps

module tb_top
  import bab_pkg::*;
();

  localparam int          ITEMS_PER_PHASE = 235;
  localparam int          PHASES          = 6;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  bab_req_t         req_i       = '0;
  logic             done_o;
  bab_res_t         res_o;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  int               pending_cnt;
  int               fail_cnt;
  int unsigned      cyc = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  block_allocation_bitmap_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  bab_alloc_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pending_o  (pending_cnt),
    .fail_cnt_o (fail_cnt)
  );

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic bab_req_t req_of(input logic [REQ_W-1:0] kind, input int idx);
    bab_req_t rq;
    rq.req_type    = kind;
    rq.block_index = IDX_W'(idx);
    return rq;
  endfunction

  function automatic bab_req_t rand_request(input int nb);
    bab_req_t rq;
    int       p;
    int       q;
    p = $urandom_range(0, 99);
    if (p < 15)      rq.req_type = REQ_CHECK_READ;
    else if (p < 50) rq.req_type = REQ_WRITE;
    else if (p < 70) rq.req_type = REQ_FREE;
    else if (p < 90) rq.req_type = REQ_FIND_FREE;
    else if (p < 92) rq.req_type = REQ_FORMAT;
    else if (p < 95) rq.req_type = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
    else             rq.req_type = REQ_W'($urandom);
    q = $urandom_range(0, 99);
    if (q < 45)      rq.block_index = IDX_W'($urandom_range(0, nb - 1));
    else if (q < 65) rq.block_index = IDX_W'($urandom_range(0, (nb > 64) ? 63 : nb - 1));
    else if (q < 80) begin
      case ($urandom_range(0, 3))
        0:       rq.block_index = '0;
        1:       rq.block_index = IDX_W'(nb - 1);
        2:       rq.block_index = IDX_W'(nb);
        default: rq.block_index = '1;
      endcase
    end else     rq.block_index = IDX_W'($urandom);
    return rq;
  endfunction

  // called at a rising edge; returns at the edge that takes the item
  task automatic issue(input bab_req_t rq);
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_num_blocks(input logic [CNT_W-1:0] v, output int eff);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (v == '0)                     eff = 1;
    else if (v > CNT_W'(MAX_BLOCKS)) eff = MAX_BLOCKS;
    else                             eff = int'(v);
  endtask

  initial begin
    logic [CNT_W-1:0] cfg_val;
    int               nb;
    int               idle_pct;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full-size store
    write_num_blocks(NB_RESET, nb);
    issue(req_of(REQ_CHECK_READ, 0));     // free block -> error
    issue(req_of(REQ_WRITE, 0));          // pointer moves on
    issue(req_of(REQ_WRITE, MAX_BLOCKS - 1));
    issue(req_of(REQ_CHECK_READ, 0));
    issue(req_of(REQ_CHECK_READ, MAX_BLOCKS - 1));
    issue(req_of(REQ_FIND_FREE, MAX_BLOCKS - 1));  // nothing free from here
    issue(req_of(REQ_FIND_FREE, 0));
    issue(req_of(REQ_FREE, MAX_BLOCKS - 1));
    issue(req_of(REQ_FREE, MAX_BLOCKS - 1));       // already free
    issue(req_of(REQ_WRITE, 2));
    issue(req_of(REQ_WRITE, 1));          // pointer skips the used block
    issue(req_of(REQ_FREE, 0));           // pointer drops back
    issue(req_of(REQ_BAD_LO, 0));
    issue(req_of(REQ_BAD_HI, MAX_BLOCKS - 1));
    issue(req_of(REQ_FORMAT, 0));

    // shrink without format: count stays above the size, frees saturate
    drain();
    write_num_blocks(13'd8, nb);
    issue(req_of(REQ_WRITE, 5));
    issue(req_of(REQ_FREE, 5));
    issue(req_of(REQ_CHECK_READ, 8));     // out of range on every request
    issue(req_of(REQ_WRITE, MAX_BLOCKS - 1));
    issue(req_of(REQ_FREE, 9));
    issue(req_of(REQ_FIND_FREE, 8));
    issue(req_of(REQ_FORMAT, 0));

    // one-block store: fill it, pointer goes invalid
    drain();
    write_num_blocks(13'd1, nb);
    issue(req_of(REQ_FORMAT, 0));
    issue(req_of(REQ_WRITE, 0));
    issue(req_of(REQ_FIND_FREE, 0));

    // count already zero must not wrap; free re-arms the pointer
    drain();
    write_num_blocks(13'd8, nb);
    issue(req_of(REQ_WRITE, 3));
    issue(req_of(REQ_FREE, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cfg_val = '1;              // clamps to the maximum
        1:       cfg_val = '0;              // clamps to one block
        2:       cfg_val = 13'd40;
        3:       cfg_val = CNT_W'($urandom_range(2, 300));
        4:       cfg_val = 13'd32;
        default: cfg_val = NB_RESET;
      endcase
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 77;
        default: idle_pct = 13;
      endcase
      drain();
      write_num_blocks(cfg_val, nb);
      if ($urandom_range(0, 1)) issue(req_of(REQ_FORMAT, 0));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk_i);
        end
        issue(rand_request(nb));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
